### sv/rbls_pkg.sv
// Shared constants and types for the row buffer lane serializer.
// No dependencies; imported by row_buffer_lane_serializer.
package rbls_pkg;

   // Store geometry
   localparam int LANES     = 8;
   localparam int ROWS      = 512;
   localparam int MAX_LANES = 8;
   localparam int CAND_W    = 64;

   // Index and count widths
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int HELD_W = $clog2(ROWS + 1);
   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

   // One stored lane: marks and candidate word
   typedef struct packed {
      logic              last;
      logic              first;
      logic              valid;
      logic [CAND_W-1:0] cand;
   } entry_type;

   typedef entry_type [LANES-1:0] row_type;

endpackage

### sv/row_buffer_lane_serializer.sv
// Row buffer lane serializer: row-wide store, read lane by lane.
// Depends on rbls_pkg.
//
// The block takes one row of LANES candidates per item and gives back one
// candidate per item, so it accepts an item every clock cycle unless the
// read stage is held by a stalled output register. A result passes through
// the read stage and the output register: the accepting edge does the
// registered read of the row store, and the output register loads from the
// read stage once it is free. The store is a single memory ROWS deep and one
// row wide, written with a whole row and read one lane per accepted item; a
// read of the row written in the same cycle is forwarded from the write data.
// Stored entries need no clearing after reset, since only written rows are
// ever read. When no row is held, the result fields are zero; a row that
// meets a full store is dropped and its result has overflow set.
module row_buffer_lane_serializer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_0,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_1,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_2,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_3,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_4,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_5,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_6,
   input  logic [rbls_pkg::CAND_W-1:0] req_cand_7,
   input  logic                      req_event_start,
   input  logic                      req_last_row,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_out_valid,
   output logic                      rsp_first_flag,
   output logic                      rsp_last_flag,
   output logic [rbls_pkg::CAND_W-1:0] rsp_candidate,
   output logic                      rsp_overflow
);
   import rbls_pkg::*;

   // Pointers and control
   logic [ROW_W-1:0]  write_row_ff, write_row_in;
   logic [ROW_W-1:0]  read_row_ff, read_row_in;
   logic [HELD_W-1:0] rows_held_ff, rows_held_in;
   logic [LANE_W-1:0] read_lane_ff, read_lane_in;
   logic              writing_open_ff, writing_open_in;

   // Read stage and output register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_empty_ff;
   logic              s1_ovf_ff;
   entry_type         rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_out_valid_ff;
   logic              rsp_first_ff;
   logic              rsp_last_ff;
   logic [CAND_W-1:0] rsp_cand_ff;
   logic              rsp_ovf_ff;

   // Row store
   row_type           row_mem [ROWS];

   logic [CAND_W-1:0] cand_lane [MAX_LANES];
   row_type           wr_row;
   logic              req_fire, out_free, s1_move;
   logic              open_now, do_write, have_read, row_done;
   logic [HELD_W-1:0] held_after_w;
   logic              seen_valid;

   assign cand_lane[0] = req_cand_0;
   assign cand_lane[1] = req_cand_1;
   assign cand_lane[2] = req_cand_2;
   assign cand_lane[3] = req_cand_3;
   assign cand_lane[4] = req_cand_4;
   assign cand_lane[5] = req_cand_5;
   assign cand_lane[6] = req_cand_6;
   assign cand_lane[7] = req_cand_7;

   // Handshake: read stage advances when the output register is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   // Build the row to store, marking the highest valid lane of a last row
   always_comb begin
      seen_valid = 1'b0;
      for (int l = LANES - 1; l >= 0; l--) begin
         wr_row[l].cand  = cand_lane[l];
         wr_row[l].valid = (cand_lane[l] != '0);
         wr_row[l].first = req_event_start && (l == 0);
         wr_row[l].last  = req_last_row && !seen_valid && (cand_lane[l] != '0);
         seen_valid      = seen_valid || (cand_lane[l] != '0);
      end
   end

   // Next pointer and count values for an accepted item
   always_comb begin
      open_now     = writing_open_ff || req_event_start;
      do_write     = open_now && (rows_held_ff != HELD_W'(ROWS));
      held_after_w = rows_held_ff + HELD_W'(do_write);
      have_read    = (held_after_w != '0);
      row_done     = have_read && (read_lane_ff == LANE_W'(LANES - 1));

      write_row_in = write_row_ff;
      if (do_write) begin
         write_row_in = (write_row_ff == ROW_W'(ROWS - 1)) ? '0 : write_row_ff + 1'b1;
      end
      read_row_in = read_row_ff;
      if (row_done) begin
         read_row_in = (read_row_ff == ROW_W'(ROWS - 1)) ? '0 : read_row_ff + 1'b1;
      end
      read_lane_in = read_lane_ff;
      if (have_read) begin
         read_lane_in = row_done ? '0 : read_lane_ff + 1'b1;
      end
      rows_held_in    = held_after_w - HELD_W'(row_done);
      writing_open_in = req_last_row ? 1'b0 : open_now;
   end

   // Advance pointers on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         write_row_ff    <= '0;
         read_row_ff     <= '0;
         rows_held_ff    <= '0;
         read_lane_ff    <= '0;
         writing_open_ff <= 1'b0;
      end else if (req_fire) begin
         write_row_ff    <= write_row_in;
         read_row_ff     <= read_row_in;
         rows_held_ff    <= rows_held_in;
         read_lane_ff    <= read_lane_in;
         writing_open_ff <= writing_open_in;
      end
   end

   // Write the row; read one lane, forwarding a same-cycle write
   always_ff @(posedge clock) begin
      if (req_fire && do_write) begin
         row_mem[write_row_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (do_write && (write_row_ff == read_row_ff)) begin
            rd_ff <= wr_row[read_lane_ff];
         end else begin
            rd_ff <= row_mem[read_row_ff][read_lane_ff];
         end
         s1_empty_ff <= !have_read;
         s1_ovf_ff   <= open_now && !do_write;
      end
   end

   // Track valid for the read stage and the output register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the output register, zeroing fields of an empty read
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_out_valid_ff <= !s1_empty_ff && rd_ff.valid;
         rsp_first_ff     <= !s1_empty_ff && rd_ff.first;
         rsp_last_ff      <= !s1_empty_ff && rd_ff.last;
         rsp_cand_ff      <= s1_empty_ff ? '0 : rd_ff.cand;
         rsp_ovf_ff       <= s1_ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = rsp_out_valid_ff;
   assign rsp_first_flag = rsp_first_ff;
   assign rsp_last_flag  = rsp_last_ff;
   assign rsp_candidate  = rsp_cand_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // Checks
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      rows_held_ff <= HELD_W'(ROWS))
      else $error("rows held exceeds store depth");

   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> $stable(rd_ff))
      else $error("read data changed while read stage stalled");

   a_empty_lane: assert property (@(posedge clock) disable iff (reset)
      req_fire && !have_read |=> $stable(read_lane_ff) && (rows_held_ff == '0))
      else $error("empty read moved the lane pointer");

   a_fire_fills: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item missing from read stage");

endmodule

### verif/tb.sv
// Testbench for row_buffer_lane_serializer: a short table of rows, then random events.
// Depends on rbls_pkg and the block's RTL; results match a local model or a typed result.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbls_pkg::*;

   localparam int                DRAIN_CYCLES = 8;
   localparam int                LONG_EVENT   = 620;
   localparam logic [CAND_W-1:0] ALL_ONES     = '1;
   localparam logic [CAND_W-1:0] TOP_BIT      = {1'b1, {(CAND_W-1){1'b0}}};

   // One input item: a row of candidates and its event marks
   typedef struct packed {
      logic [0:MAX_LANES-1][CAND_W-1:0] cand;
      logic                             start;
      logic                             last;
   } row_item_type;

   // One result item
   typedef struct packed {
      logic              out_valid;
      logic              first_flag;
      logic              last_flag;
      logic [CAND_W-1:0] candidate;
      logic              overflow;
   } lane_out_type;

   // Stimulus entry; typed entries carry a result written out by hand
   typedef struct packed {
      row_item_type item;
      logic         typed;
      lane_out_type want;
   } feed_entry_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_STRIDE} rx_mode_type;

   localparam lane_out_type EMPTY_OUT = '0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CAND_W-1:0] req_cand_0 = '0;
   logic [CAND_W-1:0] req_cand_1 = '0;
   logic [CAND_W-1:0] req_cand_2 = '0;
   logic [CAND_W-1:0] req_cand_3 = '0;
   logic [CAND_W-1:0] req_cand_4 = '0;
   logic [CAND_W-1:0] req_cand_5 = '0;
   logic [CAND_W-1:0] req_cand_6 = '0;
   logic [CAND_W-1:0] req_cand_7 = '0;
   logic              req_event_start = 1'b0;
   logic              req_last_row = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_out_valid;
   logic              rsp_first_flag;
   logic              rsp_last_flag;
   logic [CAND_W-1:0] rsp_candidate;
   logic              rsp_overflow;

   row_buffer_lane_serializer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cand_0      (req_cand_0),
      .req_cand_1      (req_cand_1),
      .req_cand_2      (req_cand_2),
      .req_cand_3      (req_cand_3),
      .req_cand_4      (req_cand_4),
      .req_cand_5      (req_cand_5),
      .req_cand_6      (req_cand_6),
      .req_cand_7      (req_cand_7),
      .req_event_start (req_event_start),
      .req_last_row    (req_last_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_first_flag  (rsp_first_flag),
      .rsp_last_flag   (rsp_last_flag),
      .rsp_candidate   (rsp_candidate),
      .rsp_overflow    (rsp_overflow)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Local copy of the row store and its pointers
   row_type     row_copy [ROWS];
   int          wr_ptr  = 0;
   int          rd_ptr  = 0;
   int          held    = 0;
   int          rd_lane = 0;
   logic        wr_open = 1'b0;

   feed_entry_type feed_q [$];
   lane_out_type   pending_lanes [$];
   feed_entry_type on_bus;
   lane_out_type   want_in;
   lane_out_type   want_out;
   int             feed_idx   = 0;
   int             fed        = 0;
   int             burst_left = 0;
   int             gap_left   = 0;
   int             mismatches = 0;
   int             rx_tick    = 0;
   rx_mode_type    rx_mode    = RX_OPEN;

   // Store one row if writing is open, then read the next lane of the oldest row
   function automatic lane_out_type next_lane_result(row_item_type it);
      lane_out_type res;
      entry_type    e;
      logic         marked;
      res    = '0;
      marked = 1'b0;
      if (it.start) wr_open = 1'b1;
      if (wr_open) begin
         if (held >= ROWS) begin
            res.overflow = 1'b1;
         end else begin
            // scan from the top lane so the last mark lands on the highest valid one
            for (int ln = LANES - 1; ln >= 0; ln--) begin
               e.cand  = it.cand[ln];
               e.valid = (it.cand[ln] != '0);
               e.first = it.start && (ln == 0);
               e.last  = it.last && !marked && e.valid;
               marked  = marked | e.last;
               row_copy[wr_ptr][ln] = e;
            end
            wr_ptr = (wr_ptr + 1) % ROWS;
            held++;
         end
      end
      if (it.last) wr_open = 1'b0;
      if (held > 0) begin
         e              = row_copy[rd_ptr][rd_lane];
         res.out_valid  = e.valid;
         res.first_flag = e.first;
         res.last_flag  = e.last;
         res.candidate  = e.cand;
         if (rd_lane == LANES - 1) begin
            rd_ptr = (rd_ptr + 1) % ROWS;
            held--;
         end
         rd_lane = (rd_lane + 1) % LANES;
      end
      return res;
   endfunction

   // Pick a candidate word: zero, all ones, a single bit, or fully random
   function automatic logic [CAND_W-1:0] rand_cand(int zero_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < zero_pct) return '0;
      if (pick < zero_pct + 5) return ALL_ONES;
      if (pick < zero_pct + 10) return TOP_BIT >> $urandom_range(0, CAND_W - 1);
      return {$urandom, $urandom};
   endfunction

   task automatic push_row(int zero_pct, logic start, logic last);
      feed_entry_type f;
      f = '0;
      for (int ln = 0; ln < MAX_LANES; ln++) f.item.cand[ln] = rand_cand(zero_pct);
      f.item.start = start;
      f.item.last  = last;
      feed_q.push_back(f);
   endtask

   // Queue an event of nrows rows; an unterminated one never marks its last row
   task automatic add_event(int nrows, int zero_pct, logic terminated);
      for (int r = 0; r < nrows; r++)
         push_row(zero_pct, r == 0, terminated && (r == nrows - 1));
   endtask

   // Mostly well-formed events with closed gaps, some broken events and noise
   task automatic add_mixed(int target);
      int kind;
      int gap;
      while (feed_q.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            add_event($urandom_range(1, 8), $urandom_range(0, 60), 1'b1);
            gap = $urandom_range(0, 24);
         end else if (kind < 85) begin
            add_event($urandom_range(1, 5), $urandom_range(0, 60), 1'b0);
            gap = $urandom_range(0, 4);
         end else begin
            gap = $urandom_range(1, 6);
         end
         repeat (gap) push_row(50, 1'b0, $urandom_range(0, 9) == 0);
      end
   endtask

   task automatic check_field(string name, logic [CAND_W-1:0] want, logic [CAND_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Fill the stimulus: directed table first, then random events
   task automatic build_feed();
      // empty store, writing closed: all zero
      feed_q.push_back(feed_entry_type'{row_item_type'{'{ALL_ONES, ALL_ONES, ALL_ONES,
         ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0, 1'b0}, 1'b1, EMPTY_OUT});
      // last row while closed: nothing stored
      feed_q.push_back(feed_entry_type'{row_item_type'{'{ALL_ONES, ALL_ONES, ALL_ONES,
         ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0, 1'b1}, 1'b1, EMPTY_OUT});
      // start and last together; lane 0 is read from the row just written
      feed_q.push_back(feed_entry_type'{row_item_type'{'{ALL_ONES, 64'h0, TOP_BIT, 64'h1,
         64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, ALL_ONES, 64'h0}, 1'b1, 1'b1},
         1'b1, lane_out_type'{1'b1, 1'b1, 1'b0, ALL_ONES, 1'b0}});
      // lane 1 holds no candidate
      feed_q.push_back(feed_entry_type'{row_item_type'{'{64'h0, 64'h0, 64'h0, 64'h0,
         64'h0, 64'h0, 64'h0, 64'h0}, 1'b0, 1'b0}, 1'b1, EMPTY_OUT});
      // drain the rest of the row while closed
      for (int k = 0; k < 6; k++) push_row(30, 1'b0, k == 2);
      // store is empty again
      feed_q.push_back(feed_entry_type'{row_item_type'{'{ALL_ONES, 64'h0, ALL_ONES, 64'h0,
         ALL_ONES, 64'h0, ALL_ONES, 64'h0}, 1'b0, 1'b0}, 1'b1, EMPTY_OUT});
      // event start on a zero lane 0: first mark without valid
      feed_q.push_back(feed_entry_type'{row_item_type'{'{64'h0, ALL_ONES, 64'h0, 64'h0,
         64'h0, 64'h0, 64'h0, TOP_BIT}, 1'b1, 1'b0}, 1'b1,
         lane_out_type'{1'b0, 1'b1, 1'b0, 64'h0, 1'b0}});
      // all-zero middle row, then a last row with no valid lane
      feed_q.push_back(feed_entry_type'{row_item_type'{'{64'h0, 64'h0, 64'h0, 64'h0,
         64'h0, 64'h0, 64'h0, 64'h0}, 1'b0, 1'b0}, 1'b0, EMPTY_OUT});
      feed_q.push_back(feed_entry_type'{row_item_type'{'{64'h0, 64'h0, 64'h0, 64'h0,
         64'h0, 64'h0, 64'h0, 64'h0}, 1'b0, 1'b1}, 1'b0, EMPTY_OUT});
      // new event, restarted while still open, closed on lane 6
      feed_q.push_back(feed_entry_type'{row_item_type'{'{64'h1, 64'h0, 64'h0, 64'h0,
         64'h0, 64'h0, 64'h0, ALL_ONES}, 1'b1, 1'b0}, 1'b0, EMPTY_OUT});
      feed_q.push_back(feed_entry_type'{row_item_type'{'{ALL_ONES, 64'h0, 64'h0,
         64'h5a5a_a5a5, 64'h0, 64'h0, TOP_BIT, 64'h0}, 1'b1, 1'b1}, 1'b0, EMPTY_OUT});
      // closed items keep reading
      for (int k = 0; k < 6; k++) push_row(40, 1'b0, k == 0);

      add_mixed(600);
      // one long event fills the store and forces dropped rows
      add_event(LONG_EVENT, 10, 1'b1);
      add_mixed(1700);
   endtask

   // Send items in bursts; predict each one as it is accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            want_in = next_lane_result(on_bus.item);
            if (on_bus.typed) want_in = on_bus.want;
            pending_lanes.push_back(want_in);
            fed++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || feed_idx >= feed_q.size()) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               on_bus = feed_q[feed_idx];
               feed_idx++;
               req_valid       <= 1'b1;
               req_cand_0      <= on_bus.item.cand[0];
               req_cand_1      <= on_bus.item.cand[1];
               req_cand_2      <= on_bus.item.cand[2];
               req_cand_3      <= on_bus.item.cand[3];
               req_cand_4      <= on_bus.item.cand[4];
               req_cand_5      <= on_bus.item.cand[5];
               req_cand_6      <= on_bus.item.cand[6];
               req_cand_7      <= on_bus.item.cand[7];
               req_event_start <= on_bus.item.start;
               req_last_row    <= on_bus.item.last;
               // close the burst and schedule the next gap
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Compare results against the oldest pending item; vary the receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_lanes.size() == 0) begin
               $error("result item with no item pending");
               mismatches++;
            end else begin
               want_out = pending_lanes.pop_front();
               check_field("out_valid", CAND_W'(want_out.out_valid), CAND_W'(rsp_out_valid));
               check_field("first_flag", CAND_W'(want_out.first_flag),
                  CAND_W'(rsp_first_flag));
               check_field("last_flag", CAND_W'(want_out.last_flag), CAND_W'(rsp_last_flag));
               check_field("candidate", want_out.candidate, rsp_candidate);
               check_field("overflow", CAND_W'(want_out.overflow), CAND_W'(rsp_overflow));
            end
         end
         rx_tick++;
         if (rx_tick % 40 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= ((rx_tick % 8) < 3);
         endcase
      end
   end

   initial begin
      build_feed();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // wait for every item to be taken and every result to come back
      while (fed < feed_q.size() || pending_lanes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### row_buffer_lane_serializer.f
sv/rbls_pkg.sv
sv/row_buffer_lane_serializer.sv
verif/tb.sv
